FILE: rtl/core/nrc_pkg.sv
// Shared constants, job control type and digit-to-character mapping for the converter.
package nrc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned DIV_STEP    = 8;
	localparam int unsigned DIGIT_W     = 6;
	localparam int unsigned CHAR_W      = 7;
	localparam int unsigned RADIX_W     = 7;

	localparam logic signed [RADIX_W-1:0] RADIX_RESET = -7'sd2;
	localparam logic signed [RADIX_W-1:0] RADIX_HI    = -7'sd2;
	localparam logic signed [RADIX_W-1:0] RADIX_LO    = -7'sd36;

	localparam logic [DIGIT_W-1:0] BASE_MIN  = 6'd2;
	localparam logic [DIGIT_W-1:0] BASE_MAX  = 6'd36;
	localparam logic [DIGIT_W-1:0] DIGIT_TOP = 6'd35;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;

	typedef struct packed {
		logic               is_zero;
		logic [DIGIT_W-1:0] base;
	} job_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] c;
		c = (d > DIGIT_TOP) ? DIGIT_TOP : d;
		if (c < DIGIT_TEN) begin
			return CHAR_ZERO + CHAR_W'(c);
		end
		return CHAR_ALPHA + CHAR_W'(c);
	endfunction

endpackage

FILE: rtl/core/nrc_front.sv
// Front end: radix register, radix clamping, zero detection and job enqueue.
module nrc_front import nrc_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [VALUE_WIDTH-1:0]        value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic signed [RADIX_W-1:0]     cfg_radix,
	input  logic                          q_full,
	output logic                          push,
	output job_ctrl_t                     push_ctrl,
	output logic [VALUE_WIDTH-1:0]        push_value
);

	logic signed [RADIX_W-1:0] radix_q;
	logic signed [RADIX_W-1:0] radix_neg;
	logic [DIGIT_W-1:0]        base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_radix;
		end
	end

	assign radix_neg = -radix_q;

	// out-of-range radices saturate to the nearest legal base
	always_comb begin
		priority if (radix_q > RADIX_HI) begin
			base = BASE_MIN;
		end else if (radix_q < RADIX_LO) begin
			base = BASE_MAX;
		end else begin
			base = radix_neg[DIGIT_W-1:0];
		end
	end

	assign cfg_ready         = 1'b1;
	assign busy              = q_full;
	assign push              = start && !q_full;
	assign push_ctrl.is_zero = (value == '0);
	assign push_ctrl.base    = base;
	assign push_value        = value;

endmodule

FILE: rtl/core/nrc_queue.sv
// Small job FIFO between front end and conversion engine.
module nrc_queue import nrc_pkg::*; #(
	parameter int unsigned W = 39
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty,
	output logic         full
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/nrc_back.sv
// Conversion engine: iterative divide by |radix|, digit stack, MSB-first digit emission.
module nrc_back import nrc_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned MAX_DIGITS  = 34
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  job_ctrl_t              job_ctrl,
	input  logic [VALUE_WIDTH-1:0] job_value,
	output logic                   digit_valid,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last_digit
);

	localparam int unsigned MAG_W  = VALUE_WIDTH;
	localparam int unsigned CHUNKS = (MAG_W + DIV_STEP - 1) / DIV_STEP;
	localparam int unsigned PW     = CHUNKS * DIV_STEP;
	localparam int unsigned CK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int unsigned AW     = $clog2(MAX_DIGITS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_FIX  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t             state_q;
	logic               neg_q;
	logic [DIGIT_W-1:0] base_q;
	logic [PW-1:0]      dq_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CK_W-1:0]    chunk_q;
	logic [CNT_W-1:0]   count_q;
	logic [AW-1:0]      rd_idx_q;

	logic [DIGIT_W-1:0] stack_mem [MAX_DIGITS];
	logic [DIGIT_W-1:0] rd_data_s1;
	logic               rd_vld_s1;
	logic               rd_last_s1;

	logic               digit_valid_q;
	logic [CHAR_W-1:0]  digit_char_q;
	logic               last_digit_q;

	logic [PW-1:0]      dq_n;
	logic [DIGIT_W-1:0] rem_n;
	logic [MAG_W-1:0]   mag_in;
	logic [MAG_W-1:0]   mq;
	logic               rem_nz;
	logic [DIGIT_W-1:0] digit;
	logic [MAG_W-1:0]   mag_next;
	logic               conv_done;
	logic               stk_we;
	logic [AW-1:0]      stk_waddr;
	logic [DIGIT_W-1:0] stk_wdata;

	// DIV_STEP restoring-division steps per cycle; remainder stays below base
	always_comb begin
		logic [DIGIT_W:0] trial;
		logic             qbit;
		dq_n  = dq_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {rem_n, dq_n[PW-1]};
			if (trial >= {1'b0, base_q}) begin
				trial = trial - {1'b0, base_q};
				qbit  = 1'b1;
			end else begin
				qbit  = 1'b0;
			end
			rem_n = trial[DIGIT_W-1:0];
			dq_n  = {dq_n[PW-2:0], qbit};
		end
	end

	assign mag_in = job_value[VALUE_WIDTH-1] ? (~job_value + MAG_W'(1)) : job_value;

	// Sign/magnitude form of the negabase step:
	// q >= 0: digit r, next q = -(|q| div b)
	// q < 0 : digit b - r (or 0), next q = (|q| div b) + (r != 0)
	assign mq        = dq_q[MAG_W-1:0];
	assign rem_nz    = (rem_q != '0);
	assign digit     = (neg_q && rem_nz) ? (base_q - rem_q) : (neg_q ? '0 : rem_q);
	assign mag_next  = (neg_q && rem_nz) ? (mq + MAG_W'(1)) : mq;
	assign conv_done = (mag_next == '0) || (count_q == CNT_W'(MAX_DIGITS - 1));

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	assign stk_we    = (q_pop && job_ctrl.is_zero) || (state_q == S_FIX);
	assign stk_waddr = (state_q == S_FIX) ? count_q[AW-1:0] : '0;
	assign stk_wdata = (state_q == S_FIX) ? digit : '0;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (state_q == S_EMIT) begin
			rd_data_s1 <= stack_mem[rd_idx_q];
			rd_last_s1 <= (rd_idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			neg_q    <= 1'b0;
			base_q   <= BASE_MIN;
			dq_q     <= '0;
			rem_q    <= '0;
			chunk_q  <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						base_q  <= job_ctrl.base;
						neg_q   <= job_value[VALUE_WIDTH-1];
						dq_q    <= PW'(mag_in);
						rem_q   <= '0;
						chunk_q <= '0;
						if (job_ctrl.is_zero) begin
							count_q  <= CNT_W'(1);
							rd_idx_q <= '0;
							state_q  <= S_EMIT;
						end else begin
							count_q <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					dq_q    <= dq_n;
					rem_q   <= rem_n;
					chunk_q <= chunk_q + 1'b1;
					if (chunk_q == CK_W'(CHUNKS - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					count_q <= count_q + 1'b1;
					neg_q   <= !neg_q;
					dq_q    <= PW'(mag_next);
					rem_q   <= '0;
					chunk_q <= '0;
					if (conv_done) begin
						rd_idx_q <= count_q[AW-1:0];
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_EMIT: begin
					if (rd_idx_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1     <= 1'b0;
			digit_valid_q <= 1'b0;
		end else begin
			rd_vld_s1     <= (state_q == S_EMIT);
			digit_valid_q <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		digit_char_q <= digit_to_char(rd_data_s1);
		last_digit_q <= rd_last_s1;
	end

	assign digit_valid = digit_valid_q;
	assign digit_char  = digit_char_q;
	assign last_digit  = last_digit_q;

endmodule

FILE: rtl/core/negative_radix_converter.sv
// Top level of the negative-radix converter: front end, job queue, conversion engine.
//
//  channel  | signals                           | beat taken when
//  ---------+-----------------------------------+------------------------------
//  input    | start, busy, value                | start && !busy
//  config   | cfg_valid, cfg_ready, cfg_radix   | cfg_valid && cfg_ready
//  result   | digit_valid, digit_char, last_digit | every cycle digit_valid is high
//
//  Each digit is produced by the divider in S_DIV (8 quotient bits per cycle) and
//  then a fix-up step in S_FIX that forms the digit and the next quotient.
//  Digits then leave one per cycle from the stack, registered in rd_data_s1 and then digit_char_q.
//  Between the front end and the engine, a 2-deep queue
//  takes new items while the engine works, and busy rises only when the queue is full.
//  arst_n clears all control state; stack contents are don't-care until written.
module negative_radix_converter import nrc_pkg::*; #(
	parameter int unsigned MAX_DIGITS  = 34,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic signed [RADIX_W-1:0]     cfg_radix,
	output logic                          digit_valid,
	output logic [CHAR_W-1:0]             digit_char,
	output logic                          last_digit
);

	localparam int unsigned CTRL_W = $bits(job_ctrl_t);
	localparam int unsigned JOB_W  = CTRL_W + VALUE_WIDTH;

	logic                   q_full;
	logic                   q_empty;
	logic                   push;
	logic                   pop;
	job_ctrl_t              push_ctrl;
	logic [VALUE_WIDTH-1:0] push_value;
	logic [JOB_W-1:0]       pop_data;
	job_ctrl_t              job_ctrl;
	logic [VALUE_WIDTH-1:0] job_value;

	nrc_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_radix (cfg_radix),
		.q_full    (q_full),
		.push      (push),
		.push_ctrl (push_ctrl),
		.push_value(push_value)
	);

	nrc_queue #(
		.W(JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctrl, push_value}),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty),
		.full     (q_full)
	);

	assign job_ctrl  = job_ctrl_t'(pop_data[JOB_W-1 -: CTRL_W]);
	assign job_value = pop_data[VALUE_WIDTH-1:0];

	nrc_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (pop),
		.job_ctrl   (job_ctrl),
		.job_value  (job_value),
		.digit_valid(digit_valid),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule

FILE: rtl/core/nrc_checker.sv
// Port-level checker for the converter, bound to the top level.
module nrc_checker import nrc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              digit_valid,
	input logic [CHAR_W-1:0] digit_char,
	input logic              last_digit
);

	localparam logic [CHAR_W-1:0] ASCII_0 = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_9 = 7'd57;
	localparam logic [CHAR_W-1:0] ASCII_A = 7'd65;
	localparam logic [CHAR_W-1:0] ASCII_Z = 7'd90;

	// every digit beat carries 0-9 or A-Z
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> ((digit_char >= ASCII_0 && digit_char <= ASCII_9) ||
		                 (digit_char >= ASCII_A && digit_char <= ASCII_Z)))
		else $error("digit_char outside 0-9/A-Z");

	// the engine passes through idle between runs, so no beat right after the final digit
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_valid && last_digit) |=> !digit_valid)
		else $error("digit beat directly after last digit");

	// busy only rises after an accepted item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted item");

	// once reset has been seen by an edge, result strobe and busy stay low
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> (!digit_valid && !busy))
		else $error("activity during reset");

endmodule

bind negative_radix_converter nrc_checker u_nrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.digit_valid(digit_valid),
	.digit_char (digit_char),
	.last_digit (last_digit)
);
